### rtl/rc_throttle_filter_hbridge_drive_defines.svh
// Assertion macros for the throttle filter and H-bridge drive block.
// Used by the top level; expects signals clk and rst in the including scope.
`ifndef RC_THROTTLE_FILTER_HBRIDGE_DRIVE_DEFINES_SVH
`define RC_THROTTLE_FILTER_HBRIDGE_DRIVE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RCTF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rctf implication check failed");

// Next-cycle implication, checked outside reset.
`define RCTF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rctf next-cycle check failed");

`endif

### rtl/rctf_pkg.sv
// Shared types and constants for the throttle filter and H-bridge drive block.
// No dependencies; used by rctf_avg, rctf_drive and the top level.
package rctf_pkg;

  localparam int WIDTH_W = 11;

  localparam logic [15:0] COUNT_TOP = 16'd10000;
  localparam logic [15:0] FAIL_LOW = 16'd900;
  localparam logic [15:0] FAIL_HIGH = 16'd2100;
  localparam logic [15:0] CLAMP_LOW = 16'd1000;
  localparam logic [15:0] CLAMP_HIGH = 16'd2000;
  localparam logic [WIDTH_W-1:0] NEUTRAL = 11'd1550;
  localparam logic [WIDTH_W-1:0] WIDTH_MIN = 11'd1000;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = 11'd2000;
  localparam logic [WIDTH_W-1:0] FWD_LIMIT = 11'd1500;
  localparam logic [WIDTH_W-1:0] BRAKE_LIMIT = 11'd1600;
  localparam logic [WIDTH_W-1:0] FWD_TOP = 11'd1499;
  localparam logic [7:0] DUTY_FULL = 8'd255;

  // x / 498 == (x * FWD_RECIP) >> FWD_SHIFT for every x up to 499 * 256
  localparam logic [17:0] FWD_RECIP = 18'd134757;
  localparam int FWD_SHIFT = 26;

  localparam logic REG_SPEED_LIMIT = 1'b0;
  localparam logic [7:0] SPEED_LIMIT_RST = 8'd255;

  typedef enum logic [1:0] {
    MODE_FORWARD = 2'd0,
    MODE_BRAKE = 2'd1,
    MODE_COAST = 2'd2
  } drive_mode_t;

  typedef struct packed {
    logic cap_load;
    logic sum_load;
    logic avg_load;
  } avg_ctl_t;

  typedef struct packed {
    logic prod_load;
    logic out_load;
  } drive_ctl_t;

endpackage

### rtl/rctf_avg.sv
// Pulse width qualification, ring buffer with running sum, and average.
// Depends on rctf_pkg; load strobes come from the top-level pipeline control.
module rctf_avg #(
  parameter int TAPS = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rctf_pkg::avg_ctl_t           ctl,
  input  logic [15:0]                  capture_count,
  output logic [rctf_pkg::WIDTH_W-1:0] avg
);

  localparam int SUM_W = $clog2(TAPS * 2000 + 1);
  localparam int POS_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int DIV_L = $clog2(TAPS);
  localparam int DIV_S = SUM_W + DIV_L;
  localparam int DIV_MW = SUM_W + 1;
  localparam int DIV_M = ((1 << DIV_S) + TAPS - 1) / TAPS;
  localparam int PROD_W = SUM_W + DIV_MW;
  localparam int SUM_RST = TAPS * 1550;

  logic [15:0]                  cap;
  logic [rctf_pkg::WIDTH_W-1:0] ring [TAPS];
  logic [POS_W-1:0]             pos;
  logic [POS_W-1:0]             pos_next;
  logic [SUM_W-1:0]             sum;
  logic [SUM_W-1:0]             sum_next;
  logic [15:0]                  raw_width;
  logic [15:0]                  qual_width;
  logic [rctf_pkg::WIDTH_W-1:0] width;
  logic [PROD_W-1:0]            div_prod;
  logic [DIV_MW-1:0]            div_m;

  // Input register
  always_ff @(posedge clk) begin
    if (ctl.cap_load) begin
      cap <= capture_count;
    end
  end

  // Width from the down-counting capture, wrapped to 16 bits
  always_comb begin
    raw_width = rctf_pkg::COUNT_TOP - cap;
    if (raw_width > rctf_pkg::FAIL_HIGH || raw_width < rctf_pkg::FAIL_LOW) begin
      qual_width = {5'd0, rctf_pkg::NEUTRAL};
    end else begin
      qual_width = raw_width;
    end
    priority if (qual_width < rctf_pkg::CLAMP_LOW) begin
      width = rctf_pkg::WIDTH_MIN;
    end else if (qual_width > rctf_pkg::CLAMP_HIGH) begin
      width = rctf_pkg::WIDTH_MAX;
    end else begin
      width = qual_width[rctf_pkg::WIDTH_W-1:0];
    end
  end

  assign sum_next = sum - SUM_W'(ring[pos]) + SUM_W'(width);
  assign pos_next = (pos == POS_W'(TAPS - 1)) ? '0 : pos + POS_W'(1);

  // Ring buffer and running sum; the sum register is also the stage payload
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        ring[i] <= rctf_pkg::NEUTRAL;
      end
      sum <= SUM_W'(SUM_RST);
      pos <= '0;
    end else if (ctl.sum_load) begin
      ring[pos] <= width;
      sum <= sum_next;
      pos <= pos_next;
    end
  end

  // Divide by TAPS through a rounded-up reciprocal, exact over the sum range
  assign div_m = DIV_MW'(DIV_M);
  assign div_prod = PROD_W'(sum) * PROD_W'(div_m);

  always_ff @(posedge clk) begin
    if (ctl.avg_load) begin
      avg <= div_prod[DIV_S +: rctf_pkg::WIDTH_W];
    end
  end

endmodule

### rtl/rctf_drive.sv
// H-bridge mode and duty mapping from the filtered width, two register stages.
// Depends on rctf_pkg; load strobes come from the top-level pipeline control.
module rctf_drive (
  input  logic                         clk,
  input  rctf_pkg::drive_ctl_t         ctl,
  input  logic [rctf_pkg::WIDTH_W-1:0] avg,
  input  logic [7:0]                   speed_limit,
  output logic [rctf_pkg::WIDTH_W-1:0] filtered_width,
  output rctf_pkg::drive_mode_t        drive_mode,
  output logic                         high_side_a,
  output logic                         high_side_b,
  output logic [7:0]                   duty_a,
  output logic [7:0]                   duty_b
);

  rctf_pkg::drive_mode_t        mode_next;
  rctf_pkg::drive_mode_t        mode;
  logic [rctf_pkg::WIDTH_W-1:0] avg_s;
  logic [rctf_pkg::WIDTH_W-1:0] fwd_diff;
  logic [17:0]                  prod_next;
  logic [17:0]                  prod;
  logic [35:0]                  quot_prod;
  logic [9:0]                   quot;
  logic [7:0]                   fwd_duty;
  logic                         hsa_next;
  logic [7:0]                   da_next;
  logic [7:0]                   db_next;

  always_comb begin
    priority if (avg < rctf_pkg::FWD_LIMIT) begin
      mode_next = rctf_pkg::MODE_FORWARD;
    end else if (avg > rctf_pkg::BRAKE_LIMIT) begin
      mode_next = rctf_pkg::MODE_BRAKE;
    end else begin
      mode_next = rctf_pkg::MODE_COAST;
    end
  end

  // Distance below the top forward width (FWD_TOP), zero outside forward
  assign fwd_diff = (mode_next == rctf_pkg::MODE_FORWARD) ? (rctf_pkg::FWD_TOP - avg) : '0;
  assign prod_next = 18'(fwd_diff[8:0]) * 18'({1'b0, speed_limit} + 9'd1);

  always_ff @(posedge clk) begin
    if (ctl.prod_load) begin
      prod <= prod_next;
      mode <= mode_next;
      avg_s <= avg;
    end
  end

  // Divide by the forward span, then saturate (top of range gives 256)
  assign quot_prod = 36'(prod) * 36'(rctf_pkg::FWD_RECIP);
  assign quot = quot_prod[rctf_pkg::FWD_SHIFT +: 10];
  assign fwd_duty = (quot > 10'(rctf_pkg::DUTY_FULL)) ? rctf_pkg::DUTY_FULL : quot[7:0];

  always_comb begin
    hsa_next = 1'b0;
    da_next = '0;
    db_next = '0;
    unique case (mode)
      rctf_pkg::MODE_FORWARD: begin
        hsa_next = 1'b1;
        da_next = fwd_duty;
      end
      rctf_pkg::MODE_BRAKE: begin
        da_next = rctf_pkg::DUTY_FULL;
        db_next = rctf_pkg::DUTY_FULL;
      end
      rctf_pkg::MODE_COAST: begin
        hsa_next = 1'b0;
      end
      default: begin
        hsa_next = 1'b0;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      filtered_width <= avg_s;
      drive_mode <= mode;
      high_side_a <= hsa_next;
      high_side_b <= 1'b0;
      duty_a <= da_next;
      duty_b <= db_next;
    end
  end

endmodule

### rtl/rc_throttle_filter_hbridge_drive.sv
// Top level: throttle pulse filter with H-bridge drive mapping.
// Depends on rctf_pkg, rctf_avg, rctf_drive and the assertion macro header.
//
//   channel   handshake                    payload
//   capture   capture_valid/capture_ready  capture_count[15:0]
//   result    result_valid/result_ready    filtered_width, drive_mode, high_side_a/b,
//                                          duty_a, duty_b
//   config    APB write/read, pready = 1   speed limit at byte address 0
//
// One capture per cycle unless a stalled result holds the pipeline back.
// Five register stages: input, running sum, average, duty product, result.
// Each stage advances when the next one is empty or advancing; a stalled result
// holds the stages behind it. Synchronous reset clears the valid bits and sets the ring
// buffer (all entries 1550), the running sum (TAPS * 1550) and the speed limit (255).
`include "rc_throttle_filter_hbridge_drive_defines.svh"

module rc_throttle_filter_hbridge_drive #(
  parameter int TAPS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        capture_valid,
  output logic        capture_ready,
  input  logic [15:0] capture_count,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [10:0] filtered_width,
  output logic [1:0]  drive_mode,
  output logic        high_side_a,
  output logic        high_side_b,
  output logic [7:0]  duty_a,
  output logic [7:0]  duty_b,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                  speed_limit_wr;
  logic [7:0]            speed_limit;
  logic                  v_cap;
  logic                  v_sum;
  logic                  v_avg;
  logic                  v_prod;
  rctf_pkg::avg_ctl_t    avg_ctl;
  rctf_pkg::drive_ctl_t  drive_ctl;
  logic [10:0]           avg;
  rctf_pkg::drive_mode_t mode_out;

  // Configuration register
  assign pready = 1'b1;
  assign speed_limit_wr = psel && penable && pwrite && (paddr[2] == rctf_pkg::REG_SPEED_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit <= rctf_pkg::SPEED_LIMIT_RST;
    end else if (speed_limit_wr) begin
      speed_limit <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == rctf_pkg::REG_SPEED_LIMIT) ? {24'd0, speed_limit} : '0;

  // Pipeline advance, back to front
  assign drive_ctl.out_load = v_prod && (!result_valid || result_ready);
  assign drive_ctl.prod_load = v_avg && (!v_prod || drive_ctl.out_load);
  assign avg_ctl.avg_load = v_sum && (!v_avg || drive_ctl.prod_load);
  assign avg_ctl.sum_load = v_cap && (!v_sum || avg_ctl.avg_load);
  assign capture_ready = !v_cap || avg_ctl.sum_load;
  assign avg_ctl.cap_load = capture_valid && capture_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_cap <= 1'b0;
      v_sum <= 1'b0;
      v_avg <= 1'b0;
      v_prod <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (avg_ctl.cap_load) begin
        v_cap <= 1'b1;
      end else if (avg_ctl.sum_load) begin
        v_cap <= 1'b0;
      end
      if (avg_ctl.sum_load) begin
        v_sum <= 1'b1;
      end else if (avg_ctl.avg_load) begin
        v_sum <= 1'b0;
      end
      if (avg_ctl.avg_load) begin
        v_avg <= 1'b1;
      end else if (drive_ctl.prod_load) begin
        v_avg <= 1'b0;
      end
      if (drive_ctl.prod_load) begin
        v_prod <= 1'b1;
      end else if (drive_ctl.out_load) begin
        v_prod <= 1'b0;
      end
      if (drive_ctl.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  rctf_avg #(
    .TAPS(TAPS)
  ) u_avg (
    .clk          (clk),
    .rst          (rst),
    .ctl          (avg_ctl),
    .capture_count(capture_count),
    .avg          (avg)
  );

  rctf_drive u_drive (
    .clk           (clk),
    .ctl           (drive_ctl),
    .avg           (avg),
    .speed_limit   (speed_limit),
    .filtered_width(filtered_width),
    .drive_mode    (mode_out),
    .high_side_a   (high_side_a),
    .high_side_b   (high_side_b),
    .duty_a        (duty_a),
    .duty_b        (duty_b)
  );

  assign drive_mode = mode_out;

  `RCTF_ASSERT_IMPL(a_width_range, result_valid, filtered_width >= 11'd1000 && filtered_width <= 11'd2000)
  `RCTF_ASSERT_IMPL(a_fwd_side, result_valid && mode_out == rctf_pkg::MODE_FORWARD, high_side_a && duty_b == 8'd0 && filtered_width < 11'd1500)
  `RCTF_ASSERT_IMPL(a_brake_duty, result_valid && mode_out == rctf_pkg::MODE_BRAKE, duty_a == 8'd255 && duty_b == 8'd255 && !high_side_a)
  `RCTF_ASSERT_NEXT(a_sum_flows, avg_ctl.sum_load && !avg_ctl.avg_load, v_sum)

endmodule

### tb/sv/tb_rc_throttle_filter_hbridge_drive.sv
// Self-checking bench for the throttle filter and H-bridge drive block.
// Predicts each drive result from accepted captures; needs rctf_pkg and the RTL.
`timescale 1ns / 1ps

module tb_rc_throttle_filter_hbridge_drive;
  import rctf_pkg::*;

  localparam int TAPS = 5;
  localparam int FWD_SPAN = 498;
  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0] ADDR_SPEED_LIMIT = 3'(4 * REG_SPEED_LIMIT);
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  typedef struct packed {
    logic [10:0] width;
    drive_mode_t mode;
    logic        hsa;
    logic        hsb;
    logic [7:0]  duty_a;
    logic [7:0]  duty_b;
  } drive_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        capture_valid = 1'b0;
  logic        capture_ready;
  logic [15:0] capture_count = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [10:0] filtered_width;
  logic [1:0]  drive_mode;
  logic        high_side_a;
  logic        high_side_b;
  logic [7:0]  duty_a;
  logic [7:0]  duty_b;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [10:0] width_hist [TAPS];
  logic [13:0] width_sum;
  int          hist_pos;
  logic [7:0]  speed_limit_cfg;

  logic [15:0]   capture_backlog [$];
  drive_result_t pending_drive [$];
  int            mismatches = 0;
  int            send_gap = 0;
  int            stall_left = 0;
  int            drv_calm = 0;
  int            mon_calm = 0;
  int unsigned   cycle_count = 0;

  rc_throttle_filter_hbridge_drive #(.TAPS(TAPS)) dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic drive_result_t predict_drive(input logic [15:0] cap);
    logic [15:0]   w;
    logic [10:0]   avg;
    int            duty;
    drive_result_t r;
    w = COUNT_TOP - cap;
    // implausible pulse falls back to neutral before the clamp
    if (w > FAIL_HIGH || w < FAIL_LOW) w = 16'(NEUTRAL);
    if (w < CLAMP_LOW) w = CLAMP_LOW;
    else if (w > CLAMP_HIGH) w = CLAMP_HIGH;
    width_sum = width_sum - 14'(width_hist[hist_pos]) + 14'(w);
    width_hist[hist_pos] = w[10:0];
    hist_pos = (hist_pos + 1) % TAPS;
    avg = 11'(width_sum / TAPS);
    r.width = avg;
    r.mode = MODE_COAST;
    r.hsa = 1'b0;
    r.hsb = 1'b0;
    r.duty_a = '0;
    r.duty_b = '0;
    if (avg < FWD_LIMIT) begin
      duty = (int'(FWD_TOP) - int'(avg)) * (int'(speed_limit_cfg) + 1) / FWD_SPAN;
      if (duty > int'(DUTY_FULL)) duty = int'(DUTY_FULL);
      r.mode = MODE_FORWARD;
      r.hsa = 1'b1;
      r.duty_a = 8'(duty);
    end else if (avg > BRAKE_LIMIT) begin
      r.mode = MODE_BRAKE;
      r.duty_a = DUTY_FULL;
      r.duty_b = DUTY_FULL;
    end
    return r;
  endfunction

  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm = $urandom_range(30, 120);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // one APB transfer; a write updates the predictor, a read is checked
  task automatic apb_access(input bit is_write, input logic [2:0] addr,
                            input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (is_write) begin
      if (addr == ADDR_SPEED_LIMIT) speed_limit_cfg = data[7:0];
    end else if (prdata !== {24'b0, speed_limit_cfg}) begin
      note_mismatch($sformatf("speed limit read exp %0d got %0d", speed_limit_cfg, prdata));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (capture_backlog.size() != 0 || capture_valid || pending_drive.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly steady stick holds near the thresholds, with raw noise mixed in
  task automatic queue_random(input int n);
    int left;
    int hold;
    int target;
    int wv;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 99) < 15) begin
        capture_backlog.push_back(16'($urandom_range(0, 65535)));
        left--;
      end else begin
        case ($urandom_range(0, 5))
          0: target = $urandom_range(850, 2150);
          1: target = $urandom_range(1490, 1510);
          2: target = $urandom_range(1590, 1610);
          3: target = $urandom_range(995, 1005);
          4: target = $urandom_range(1995, 2005);
          default: target = $urandom_range(0, 1) ? $urandom_range(895, 905)
                                                 : $urandom_range(2095, 2105);
        endcase
        hold = $urandom_range(3, 12);
        while (hold > 0 && left > 0) begin
          wv = target;
          if ($urandom_range(0, 3) == 0) wv = target + $urandom_range(0, 4) - 2;
          capture_backlog.push_back(16'(10000 - wv));
          hold--;
          left--;
        end
      end
    end
  endtask

  always @(posedge clk) begin : capture_driver
    if (rst) begin
      capture_valid <= 1'b0;
    end else begin
      if (capture_valid && capture_ready) pending_drive.push_back(predict_drive(capture_count));
      if (!capture_valid || capture_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          capture_valid <= 1'b0;
        end else if (capture_backlog.size() != 0) begin
          capture_valid <= 1'b1;
          capture_count <= capture_backlog.pop_front();
          send_gap = next_gap(drv_calm);
        end else begin
          capture_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    drive_result_t want;
    drive_result_t got;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        got.width = filtered_width;
        got.mode = drive_mode_t'(drive_mode);
        got.hsa = high_side_a;
        got.hsb = high_side_b;
        got.duty_a = duty_a;
        got.duty_b = duty_b;
        if (pending_drive.size() == 0) begin
          note_mismatch($sformatf("unexpected result width %0d mode %0d", got.width, got.mode));
        end else begin
          want = pending_drive.pop_front();
          if (got !== want)
            note_mismatch($sformatf(
              "width %0d/%0d mode %0d/%0d hsa %0b/%0b hsb %0b/%0b duty_a %0d/%0d duty_b %0d/%0d",
              want.width, got.width, want.mode, got.mode, want.hsa, got.hsa,
              want.hsb, got.hsb, want.duty_a, got.duty_a, want.duty_b, got.duty_b));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        stall_left = next_gap(mon_calm);
      end
    end
  end

  initial begin
    logic [7:0] setting;
    for (int i = 0; i < TAPS; i++) width_hist[i] = NEUTRAL;
    width_sum = 14'(TAPS * NEUTRAL);
    hist_pos = 0;
    speed_limit_cfg = SPEED_LIMIT_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // wrapped and out-of-window widths, window edges, clamp edges, then full
    // forward (duty saturates), brake and coast holds
    capture_backlog = {16'd0, 16'd65535, 16'd10000, 16'd10001, 16'd9100, 16'd9101,
                       16'd7900, 16'd7899, 16'd9000, 16'd8000,
                       16'd9000, 16'd9000, 16'd9000, 16'd9000, 16'd9000,
                       16'd8000, 16'd8000, 16'd8000, 16'd8000, 16'd8000,
                       16'd8450, 16'd8450, 16'd8450, 16'd8450, 16'd8450};
    wait_drained();
    apb_access(1'b0, ADDR_SPEED_LIMIT, '0);
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: setting = 8'd0;
        1: setting = 8'd255;
        2: setting = 8'd1;
        3: setting = 8'd37;
        4: setting = 8'd128;
        default: setting = 8'($urandom_range(0, 255));
      endcase
      // upper bits of the write data must be ignored
      apb_access(1'b1, ADDR_SPEED_LIMIT, {24'($urandom), setting});
      if (p == 2) apb_access(1'b1, ADDR_UNUSED, $urandom);
      apb_access(1'b0, ADDR_SPEED_LIMIT, '0);
      @(negedge clk);
      queue_random(250);
      wait_drained();
    end
    if (mismatches == 0 && pending_drive.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/rctf_pkg.sv
rtl/rctf_avg.sv
rtl/rctf_drive.sv
rtl/rc_throttle_filter_hbridge_drive.sv
tb/sv/tb_rc_throttle_filter_hbridge_drive.sv
